@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every edge outside reset
`define GMPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// check on every edge, reset included
`define GMPS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ sv/gmps_pkg.sv @@
`timescale 1ns / 1ps
package gmps_pkg;
    localparam int unsigned COST_W           = 16;
    localparam int unsigned SUM_W            = 32;
    localparam int unsigned ROW_WIDTH_W      = 11;
    localparam int unsigned MAX_COLS_DEFAULT = 1024;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = ROW_WIDTH_W'(1024);
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
endpackage

@@ sv/grid_min_path_sum_top.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake                  word
// in        sink       i_in_valid / o_in_ready    i_cell_cost, i_grid_start
// out       source     o_out_valid / i_out_ready  o_path_sum, o_row_end
// cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_row_width
//
// One cell per cycle sustained while the output drains; an output stall holds the input.
// Set by the single read/write port pair of the row-sum memory and the min-and-add step
// that feeds the left and diagonal sums back into the next cell.
// Synchronous active-low reset clears control state; row width resets to 1024.
// The row-sum memory is not cleared. No clearing pass, cells are taken right after reset.
// A stalled output holds its word; one more cell is taken into the middle stage.
module grid_min_path_sum_top #(
    parameter int unsigned MAX_COLS = gmps_pkg::MAX_COLS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [gmps_pkg::COST_W-1:0]      i_cell_cost,
    input  logic                             i_grid_start,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [gmps_pkg::SUM_W-1:0]       o_path_sum,
    output logic                             o_row_end,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gmps_pkg::ROW_WIDTH_W-1:0] i_cfg_row_width
);
    import gmps_pkg::*;

    localparam int unsigned COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int unsigned AW_W   = $clog2(MAX_COLS + 1);
    localparam int unsigned CMP_W  = ((AW_W > ROW_WIDTH_W) ? AW_W : ROW_WIDTH_W) + 1;

    logic [ROW_WIDTH_W-1:0] r_row_width;
    logic [COL_W-1:0]       r_col;
    logic                   r_first_row;

    logic                   r_s1_valid;
    logic [COST_W-1:0]      r_s1_cost;
    logic [COL_W-1:0]       r_s1_col;
    logic                   r_s1_first;
    logic                   r_s1_last;
    logic                   r_s1_fwd;
    logic [SUM_W-1:0]       r_rd_data;

    logic [SUM_W-1:0]       r_left_sum;
    logic [SUM_W-1:0]       r_diag_sum;

    logic                   r_out_valid;
    logic [SUM_W-1:0]       r_out_sum;
    logic                   r_out_end;

    logic [SUM_W-1:0]       r_mem [MAX_COLS];

    logic                   in_fire;
    logic                   s1_fire;
    logic [COL_W-1:0]       cur_col;
    logic                   cur_first;
    logic [CMP_W-1:0]       cfg_ext;
    logic [CMP_W-1:0]       active_w;
    logic [CMP_W-1:0]       col_inc;
    logic                   cur_last;
    logic [COL_W-1:0]       n_col;
    logic                   n_first_row;

    logic [SUM_W-1:0]       above;
    logic [SUM_W-1:0]       min_al;
    logic [SUM_W-1:0]       min3;
    logic [SUM_W-1:0]       base;
    logic [SUM_W:0]         sum_wide;
    logic [SUM_W-1:0]       n_sum;

    assign o_cfg_ready = 1'b1;
    assign s1_fire     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || s1_fire;
    assign in_fire     = i_in_valid && o_in_ready;

    always_comb begin
        cur_col   = i_grid_start ? '0 : r_col;
        cur_first = i_grid_start ? 1'b1 : r_first_row;
        cfg_ext   = CMP_W'(r_row_width);
        if (cfg_ext == '0) begin
            active_w = CMP_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_COLS)) begin
            active_w = CMP_W'(MAX_COLS);
        end else begin
            active_w = cfg_ext;
        end
        col_inc  = CMP_W'(cur_col) + CMP_W'(1);
        cur_last = (col_inc >= active_w);
        if (cur_last) begin
            n_col       = '0;
            n_first_row = 1'b0;
        end else begin
            n_col       = col_inc[COL_W-1:0];
            n_first_row = cur_first;
        end
    end

    always_comb begin
        if (r_s1_first) begin
            above = '0;
        end else if (r_s1_fwd) begin
            above = r_left_sum;
        end else begin
            above = r_rd_data;
        end
        min_al = (r_left_sum < above) ? r_left_sum : above;
        min3   = (r_diag_sum < min_al) ? r_diag_sum : min_al;
        if (r_s1_first) begin
            base = (r_s1_col == '0) ? '0 : r_left_sum;
        end else begin
            base = (r_s1_col == '0) ? above : min3;
        end
        sum_wide = {1'b0, base} + (SUM_W + 1)'(r_s1_cost);
        n_sum    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_mem[r_s1_col] <= n_sum;
        end
        if (in_fire) begin
            r_rd_data <= r_mem[cur_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RESET;
            r_col       <= '0;
            r_first_row <= 1'b1;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_left_sum  <= '0;
            r_diag_sum  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_row_width <= i_cfg_row_width;
            end
            if (in_fire) begin
                r_col       <= n_col;
                r_first_row <= n_first_row;
                r_s1_valid  <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid  <= 1'b0;
            end
            if (s1_fire) begin
                r_left_sum  <= n_sum;
                r_diag_sum  <= above;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_cost  <= i_cell_cost;
            r_s1_col   <= cur_col;
            r_s1_first <= cur_first;
            r_s1_last  <= cur_last;
            r_s1_fwd   <= s1_fire && (r_s1_col == cur_col);
        end
        if (s1_fire) begin
            r_out_sum <= n_sum;
            r_out_end <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_path_sum  = r_out_sum;
    assign o_row_end   = r_out_end;
endmodule

@@ sv/gmps_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gmps_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [gmps_pkg::SUM_W-1:0]   o_path_sum,
    input logic                         o_row_end
);
    import gmps_pkg::*;

    `GMPS_ASSERT_ALWAYS(a_idle_after_reset, i_clk, !i_rst_n |=> !o_out_valid, "output valid right after reset")
    `GMPS_ASSERT(a_empty_takes_input, i_clk, i_rst_n, !o_out_valid |-> o_in_ready, "input blocked with empty output")
    `GMPS_ASSERT(a_stall_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_path_sum) && $stable(o_row_end), "stalled output word changed")
endmodule

bind grid_min_path_sum_top gmps_checker u_gmps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_path_sum  (o_path_sum),
    .o_row_end   (o_row_end)
);

@@ tb/grid_min_path_sum_top_test.sv @@
`timescale 1ns / 1ps
module grid_min_path_sum_top_test;
    import gmps_pkg::*;

    localparam int unsigned NCOLS       = MAX_COLS_DEFAULT;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          TAIL_CYCLES = 8;
    localparam int          SEGMENTS    = 12;
    localparam int          SEG_CELLS   = 112;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             row_end;
    } t_path_word;

    typedef enum logic {ROW_CELL, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [ROW_WIDTH_W-1:0] width;
        logic [COST_W-1:0]      cost;
        logic                   start;
        logic                   typed;
        logic [SUM_W-1:0]       sum;
        logic                   row_end;
    } t_plan_row;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_in_valid      = 1'b0;
    logic [COST_W-1:0]      i_cell_cost     = '0;
    logic                   i_grid_start    = 1'b0;
    logic                   i_out_ready     = 1'b0;
    logic                   i_cfg_valid     = 1'b0;
    logic [ROW_WIDTH_W-1:0] i_cfg_row_width = '0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [SUM_W-1:0]       o_path_sum;
    logic                   o_row_end;
    logic                   o_cfg_ready;

    grid_min_path_sum_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cell_cost     (i_cell_cost),
        .i_grid_start    (i_grid_start),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_path_sum      (o_path_sum),
        .o_row_end       (o_row_end),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_row_width (i_cfg_row_width)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [SUM_W-1:0]       row_sum_mem   [NCOLS];
    bit                     row_sum_valid [NCOLS];
    logic [SUM_W-1:0]       left_acc      = '0;
    logic [SUM_W-1:0]       diag_acc      = '0;
    int unsigned            col_pos       = 0;
    bit                     on_top_row    = 1'b1;
    logic [ROW_WIDTH_W-1:0] row_width_q   = ROW_WIDTH_RESET;

    t_path_word pending_sums [$];
    t_path_word rx_word;
    int         err_count   = 0;
    int         idle_cycles = 0;
    int         gap_pct     = 0;
    int         stall_pct   = 0;

    t_plan_row plan [23] = '{
        '{ROW_CELL, 11'd0,    16'd5,    1'b0, 1'b1, 32'd5,     1'b0},
        '{ROW_CELL, 11'd0,    16'hFFFF, 1'b0, 1'b1, 32'd65540, 1'b0},
        '{ROW_CELL, 11'd0,    16'd0,    1'b1, 1'b1, 32'd0,     1'b0},
        '{ROW_CELL, 11'd0,    16'hFFFF, 1'b0, 1'b1, 32'd65535, 1'b0},
        '{ROW_CFG,  11'd1,    16'd0,    1'b0, 1'b0, 32'd0,     1'b0},
        '{ROW_CELL, 11'd0,    16'd7,    1'b0, 1'b1, 32'd65542, 1'b1},
        '{ROW_CELL, 11'd0,    16'hFFFF, 1'b0, 1'b1, 32'd65535, 1'b1},
        '{ROW_CELL, 11'd0,    16'd0,    1'b0, 1'b1, 32'd65535, 1'b1},
        '{ROW_CFG,  11'd0,    16'd0,    1'b0, 1'b0, 32'd0,     1'b0},
        '{ROW_CELL, 11'd0,    16'd1,    1'b0, 1'b1, 32'd65536, 1'b1},
        '{ROW_CFG,  11'd3,    16'd0,    1'b0, 1'b0, 32'd0,     1'b0},
        '{ROW_CELL, 11'd0,    16'd3,    1'b1, 1'b1, 32'd3,     1'b0},
        '{ROW_CELL, 11'd0,    16'd1,    1'b0, 1'b1, 32'd4,     1'b0},
        '{ROW_CELL, 11'd0,    16'd2,    1'b0, 1'b1, 32'd6,     1'b1},
        '{ROW_CELL, 11'd0,    16'd0,    1'b0, 1'b0, 32'd0,     1'b0},
        '{ROW_CELL, 11'd0,    16'd10,   1'b0, 1'b0, 32'd0,     1'b0},
        '{ROW_CELL, 11'd0,    16'hFFFF, 1'b0, 1'b0, 32'd0,     1'b0},
        '{ROW_CELL, 11'd0,    16'd0,    1'b0, 1'b0, 32'd0,     1'b0},
        '{ROW_CFG,  11'd2047, 16'd0,    1'b0, 1'b0, 32'd0,     1'b0},
        '{ROW_CELL, 11'd0,    16'd8,    1'b0, 1'b0, 32'd0,     1'b0},
        '{ROW_CELL, 11'd0,    16'd9,    1'b0, 1'b0, 32'd0,     1'b0},
        '{ROW_CELL, 11'd0,    16'hAAAA, 1'b1, 1'b1, 32'd43690, 1'b0},
        '{ROW_CELL, 11'd0,    16'h5555, 1'b0, 1'b1, 32'd65535, 1'b0}
    };

    logic [ROW_WIDTH_W-1:0] seg_width [10] = '{
        11'd0, 11'd4, 11'd2047, 11'd1, 11'd7, 11'd1024, 11'd2, 11'd13, 11'd3, 11'd33
    };

    function automatic t_path_word predict_cell(input logic [COST_W-1:0] cost,
                                                input logic start);
        t_path_word       word;
        logic [SUM_W-1:0] above;
        logic [SUM_W-1:0] best;
        logic [SUM_W:0]   total;
        int unsigned      span;
        span = (row_width_q == 0) ? 1 : ((row_width_q > NCOLS) ? NCOLS : row_width_q);
        if (start) begin
            col_pos    = 0;
            on_top_row = 1'b1;
        end
        above = '0;
        if (on_top_row) begin
            best = (col_pos == 0) ? '0 : left_acc;
        end else begin
            above = row_sum_mem[col_pos];
            best  = above;
            if (col_pos != 0) begin
                if (left_acc < best) best = left_acc;
                if (diag_acc < best) best = diag_acc;
            end
        end
        total    = {1'b0, best} + cost;
        word.sum = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
        diag_acc = above;
        left_acc = word.sum;
        row_sum_mem[col_pos]   = word.sum;
        row_sum_valid[col_pos] = 1'b1;
        word.row_end = (col_pos + 1 >= span);
        if (word.row_end) begin
            col_pos    = 0;
            on_top_row = 1'b0;
        end else begin
            col_pos = col_pos + 1;
        end
        return word;
    endfunction

    task automatic send_cell(input logic [COST_W-1:0] cost, input logic start,
                             output t_path_word word);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cell_cost  <= cost;
        i_grid_start <= start;
        do @(posedge i_clk); while (!o_in_ready);
        word = predict_cell(cost, start);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [ROW_WIDTH_W-1:0] width);
        i_cfg_row_width <= width;
        i_cfg_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        row_width_q = width;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_sums.size() == 0) begin
                    $error("path_sum: word with nothing expected, got %0h", o_path_sum);
                    err_count++;
                end else begin
                    rx_word = pending_sums.pop_front();
                    if (o_path_sum !== rx_word.sum) begin
                        $error("path_sum: expected %0h, got %0h", rx_word.sum, o_path_sum);
                        err_count++;
                    end
                    if (o_row_end !== rx_word.row_end) begin
                        $error("row_end: expected %0b, got %0b", rx_word.row_end, o_row_end);
                        err_count++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_path_word             word;
        logic [COST_W-1:0]      cost;
        logic                   start;
        logic [ROW_WIDTH_W-1:0] width;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                settle();
                write_width(plan[r].width);
            end else begin
                send_cell(plan[r].cost, plan[r].start, word);
                if (plan[r].typed) begin
                    pending_sums.push_back(t_path_word'{plan[r].sum, plan[r].row_end});
                end else begin
                    pending_sums.push_back(word);
                end
            end
        end

        for (int s = 0; s < SEGMENTS; s++) begin
            settle();
            case (s % 4)
                0: begin gap_pct = 0;  stall_pct <= 0;  end
                1: begin gap_pct = 63; stall_pct <= 0;  end
                2: begin gap_pct = 0;  stall_pct <= 63; end
                default: begin gap_pct = 38; stall_pct <= 38; end
            endcase
            width = (s < 10) ? seg_width[s] : ROW_WIDTH_W'($urandom_range(1, 24));
            write_width(width);
            for (int n = 0; n < SEG_CELLS; n++) begin
                case ($urandom_range(0, 3))
                    0: cost = COST_W'($urandom_range(0, 65535));
                    1: cost = COST_W'($urandom_range(0, 15));
                    2: cost = COST_W'($urandom_range(0, 255));
                    default: cost = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                endcase
                start = ($urandom_range(0, 49) == 0);
                // restart the grid rather than read a row buffer entry never written
                start = start || (!on_top_row && !row_sum_valid[col_pos]);
                send_cell(cost, start, word);
                pending_sums.push_back(word);
            end
        end

        settle();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/gmps_pkg.sv
sv/grid_min_path_sum_top.sv
sv/gmps_checker.sv
tb/grid_min_path_sum_top_test.sv
